/* rtl/rmv_pkg.sv */
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared types, constants and saturation helpers for the running statistics
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmv_pkg;

  localparam int VAL_W            = 32;
  localparam int WGT_W            = 16;
  localparam int TOT_W            = 40;
  localparam int ACC_W            = 64;
  localparam int WEIGHT_FRAC_BITS = 8;

  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 72;
  localparam int DIV_D_W = 40;
  localparam int WIDE_W  = 75;

  localparam logic [TOT_W-1:0] ONE_W     = 40'd256;
  localparam logic [TOT_W-1:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_DIV,
    S_ADD_MUL,
    S_REM_MUL1,
    S_REM_DIV,
    S_REM_MUL2,
    S_WS_MUL,
    S_VAR,
    S_VAR_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               neg;
    logic [MUL_P_W-1:0] mag;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               neg;
    logic [DIV_N_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [32:0] abs33(input logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction

  function automatic logic signed [WIDE_W-1:0] sm_to_wide(input logic neg,
                                                          input logic [MUL_P_W-1:0] mag);
    logic signed [WIDE_W-1:0] e;
    e = $signed({2'b00, mag});
    return neg ? -e : e;
  endfunction

  function automatic logic signed [31:0] sat32_s(input logic signed [WIDE_W-1:0] x);
    if (x > 75'sd2147483647) return 32'sh7FFF_FFFF;
    else if (x < -75'sd2147483648) return 32'sh8000_0000;
    else return x[31:0];
  endfunction

  function automatic logic signed [63:0] sat64_s(input logic signed [WIDE_W-1:0] x);
    if (x > 75'sd9223372036854775807) return 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (x < -75'sd9223372036854775808) return 64'sh8000_0000_0000_0000;
    else return x[63:0];
  endfunction

  function automatic logic signed [31:0] sat32_sm(input logic neg,
                                                  input logic [DIV_N_W-1:0] mag);
    logic [31:0] t;
    t = mag[31:0];
    if (!neg && mag > 72'd2147483647) return 32'sh7FFF_FFFF;
    else if (neg && mag > 72'd2147483648) return 32'sh8000_0000;
    else return neg ? $signed(-t) : $signed(t);
  endfunction

  function automatic logic signed [63:0] sat64_sm(input logic neg,
                                                  input logic [DIV_N_W-1:0] mag);
    logic [63:0] t;
    t = mag[63:0];
    if (!neg && mag > 72'd9223372036854775807) return 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (neg && mag > 72'd9223372036854775808) return 64'sh8000_0000_0000_0000;
    else return neg ? $signed(-t) : $signed(t);
  endfunction

endpackage

`default_nettype wire

/* rtl/rmv_mul.sv */
// ----------------------------------------------------------------------------
// rmv_mul
// Bit-serial sign-magnitude shift-add multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_mul
  import rmv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  mul_req_t  req,
  output mul_rsp_t  rsp
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               neg_r, neg_nxt;
  logic [MUL_A_W-1:0] a_r, a_nxt;
  logic [MUL_P_W-1:0] p_r, p_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [MUL_A_W:0]   sum;

  always_comb begin
    sum      = {1'b0, p_r[MUL_P_W-1:MUL_B_W]} + (p_r[0] ? {1'b0, a_r} : '0);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    a_nxt    = a_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      a_nxt    = req.a;
      p_nxt    = {{MUL_A_W{1'b0}}, req.b};
      neg_nxt  = req.neg;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt   = {sum, p_r[MUL_B_W-1:1]};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(MUL_B_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    a_r   <= a_nxt;
    p_r   <= p_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp = '{busy: busy_r, done: done_r, neg: neg_r, mag: p_r};

endmodule

`default_nettype wire

/* rtl/rmv_div.sv */
// ----------------------------------------------------------------------------
// rmv_div
// Bit-serial restoring divider on magnitudes, one quotient bit a cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_div
  import rmv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               neg_r, neg_nxt;
  logic [DIV_N_W-1:0] n_r, n_nxt;
  logic [DIV_D_W-1:0] den_r, den_nxt;
  logic [DIV_D_W-1:0] rem_r, rem_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic [DIV_D_W:0]   rem_t;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  always_comb begin
    rem_t    = {rem_r, n_r[DIV_N_W-1]};
    diff     = rem_t - {1'b0, den_r};
    ge       = rem_t >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    n_nxt    = n_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      n_nxt    = req.num;
      den_nxt  = req.den;
      neg_nxt  = req.neg;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_D_W-1:0] : rem_t[DIV_D_W-1:0];
      n_nxt   = {n_r[DIV_N_W-2:0], ge};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'(DIV_N_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    n_r   <= n_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp = '{busy: busy_r, done: done_r, neg: neg_r, quo: n_r};

endmodule

`default_nettype wire

/* rtl/running_mean_variance_top.sv */
// ----------------------------------------------------------------------------
// running_mean_variance_top
// Weighted running count, mean, variance and sum with add, remove and clear.
// ----------------------------------------------------------------------------
// One beat is taken at a time. Every beat ends with a serial variance
// division when the divisor exceeds one. An add also runs a serial mean
// division and two serial multiplies, and a remove three multiplies and one
// division. An add or remove that meets a zero divisor, or a remove that
// empties a total of one, skips to the weighted sum multiply. A clear and an
// unused op code go straight to the variance step. A result still held in the
// result register adds its stall time to the end of the following beat. The
// serial divider takes one quotient bit a cycle and the serial multiplier one
// bit a cycle. The result register lets the next beat be taken while a result
// waits to be collected.
`default_nettype none

module running_mean_variance_top
  import rmv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_op,
  input  wire logic [WGT_W-1:0]   in_weight,
  input  wire logic [VAL_W-1:0]   in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [TOT_W-1:0]        out_count,
  output logic [VAL_W-1:0]        out_mean_out,
  output logic [ACC_W-1:0]        out_variance_out,
  output logic [ACC_W-1:0]        out_sum_out,
  output logic                    out_div_fault,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_sample_mode
);

  state_t                   state_r, state_nxt;
  op_t                      op_r, op_nxt;
  logic [WGT_W-1:0]         w_r, w_nxt;
  logic signed [VAL_W-1:0]  v_r, v_nxt;
  logic [TOT_W-1:0]         total_r, total_nxt;
  logic signed [VAL_W-1:0]  mean_r, mean_nxt;
  logic signed [ACC_W-1:0]  sq_r, sq_nxt;
  logic signed [ACC_W-1:0]  ws_r, ws_nxt;
  logic                     mode_r, mode_nxt;
  logic                     fault_r, fault_nxt;
  logic signed [VAL_W-1:0]  nm_r, nm_nxt;
  logic signed [TOT_W:0]    d_r, d_nxt;
  logic signed [ACC_W-1:0]  var_r, var_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [TOT_W-1:0]         oc_r, oc_nxt;
  logic [VAL_W-1:0]         om_r, om_nxt;
  logic [ACC_W-1:0]         ov_r, ov_nxt;
  logic [ACC_W-1:0]         os_r, os_nxt;
  logic                     of_r, of_nxt;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [32:0]       d1, vm;
  logic signed [TOT_W:0]    tot_sum, dd, vd;
  logic [TOT_W-1:0]         tot_n;
  logic signed [WIDE_W-1:0] pw, qw, num_w;
  logic [WIDE_W-1:0]        num_abs;
  logic [TOT_W:0]           d_abs;
  logic [ACC_W-1:0]         sq_abs;
  logic signed [VAL_W-1:0]  mtmp;
  logic signed [32:0]       vmt;
  logic                     start_ws;

  rmv_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  rmv_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    w_nxt         = w_r;
    v_nxt         = v_r;
    total_nxt     = total_r;
    mean_nxt      = mean_r;
    sq_nxt        = sq_r;
    ws_nxt        = ws_r;
    mode_nxt      = (cfg_valid && cfg_ready) ? cfg_sample_mode : mode_r;
    fault_nxt     = fault_r;
    nm_nxt        = nm_r;
    d_nxt         = d_r;
    var_nxt       = var_r;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    oc_nxt        = oc_r;
    om_nxt        = om_r;
    ov_nxt        = ov_r;
    os_nxt        = os_r;
    of_nxt        = of_r;
    mul_req       = '0;
    div_req       = '0;
    start_ws      = 1'b0;

    d1      = $signed({v_r[31], v_r}) - $signed({mean_r[31], mean_r});
    tot_sum = $signed({1'b0, total_r} + {25'd0, w_r});
    tot_n   = tot_sum[TOT_W] ? TOTAL_MAX : tot_sum[TOT_W-1:0];
    dd      = $signed({1'b0, total_r} - {25'd0, w_r});
    vd      = $signed({1'b0, total_r} - (mode_r ? ONE_W : '0));
    pw      = sm_to_wide(mul_rsp.neg, mul_rsp.mag);
    qw      = sm_to_wide(div_rsp.neg, {1'b0, div_rsp.quo});
    num_w   = pw - $signed({{35{v_r[31]}}, v_r, 8'd0});
    num_abs = num_w[WIDE_W-1] ? WIDE_W'(-num_w) : WIDE_W'(num_w);
    d_abs   = d_r[TOT_W] ? (TOT_W+1)'(-d_r) : (TOT_W+1)'(d_r);
    sq_abs  = sq_r[ACC_W-1] ? ACC_W'(-sq_r) : ACC_W'(sq_r);
    mtmp    = '0;
    vm      = '0;
    vmt     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = op_t'(in_op);
          w_nxt     = in_weight;
          v_nxt     = in_value;
          fault_nxt = 1'b0;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_r)
          OP_ADD: begin
            total_nxt = tot_n;
            if (tot_n == '0) begin
              fault_nxt = 1'b1;
              start_ws  = 1'b1;
              state_nxt = S_WS_MUL;
            end else begin
              div_req   = '{start: 1'b1, neg: d1[32],
                            num: {31'd0, abs33(d1), 8'd0}, den: tot_n};
              state_nxt = S_ADD_DIV;
            end
          end
          OP_REMOVE: begin
            if (total_r == ONE_W) begin
              total_nxt = '0;
              mean_nxt  = '0;
              sq_nxt    = '0;
              start_ws  = 1'b1;
              state_nxt = S_WS_MUL;
            end else begin
              d_nxt = dd;
              if (dd == '0) begin
                fault_nxt = 1'b1;
                total_nxt = '0;
                start_ws  = 1'b1;
                state_nxt = S_WS_MUL;
              end else begin
                mul_req   = '{start: 1'b1, neg: mean_r[31], a: total_r,
                              b: abs33({mean_r[31], mean_r})};
                state_nxt = S_REM_MUL1;
              end
            end
          end
          OP_CLEAR: begin
            total_nxt = '0;
            mean_nxt  = '0;
            sq_nxt    = '0;
            ws_nxt    = '0;
            state_nxt = S_VAR;
          end
          default: state_nxt = S_VAR;
        endcase
      end
      S_ADD_DIV: begin
        if (div_rsp.done) begin
          mtmp      = sat32_s($signed({{43{mean_r[31]}}, mean_r}) + qw);
          nm_nxt    = mtmp;
          vm        = $signed({v_r[31], v_r}) - $signed({mtmp[31], mtmp});
          mul_req   = '{start: 1'b1, neg: d1[32] ^ vm[32],
                        a: {7'd0, abs33(d1)}, b: abs33(vm)};
          state_nxt = S_ADD_MUL;
        end
      end
      S_ADD_MUL: begin
        if (mul_rsp.done) begin
          sq_nxt    = sat64_s($signed({{11{sq_r[63]}}, sq_r}) + pw);
          mean_nxt  = nm_r;
          start_ws  = 1'b1;
          state_nxt = S_WS_MUL;
        end
      end
      S_REM_MUL1: begin
        if (mul_rsp.done) begin
          div_req   = '{start: 1'b1, neg: num_w[WIDE_W-1] ^ d_r[TOT_W],
                        num: num_abs[DIV_N_W-1:0], den: d_abs[DIV_D_W-1:0]};
          state_nxt = S_REM_DIV;
        end
      end
      S_REM_DIV: begin
        if (div_rsp.done) begin
          mtmp      = sat32_sm(div_rsp.neg, div_rsp.quo);
          nm_nxt    = mtmp;
          vm        = $signed({v_r[31], v_r}) - $signed({mtmp[31], mtmp});
          mul_req   = '{start: 1'b1, neg: d1[32] ^ vm[32],
                        a: {7'd0, abs33(d1)}, b: abs33(vm)};
          state_nxt = S_REM_MUL2;
        end
      end
      S_REM_MUL2: begin
        if (mul_rsp.done) begin
          sq_nxt    = sat64_s($signed({{11{sq_r[63]}}, sq_r}) - pw);
          mean_nxt  = nm_r;
          total_nxt = d_r[TOT_W] ? '0 : d_r[TOT_W-1:0];
          start_ws  = 1'b1;
          state_nxt = S_WS_MUL;
        end
      end
      S_WS_MUL: begin
        if (mul_rsp.done) begin
          ws_nxt    = sat64_s($signed({{11{ws_r[63]}}, ws_r}) +
                              ((op_r == OP_ADD) ? pw : -pw));
          state_nxt = S_VAR;
        end
      end
      S_VAR: begin
        if (vd > 41'sd256) begin
          div_req   = '{start: 1'b1, neg: sq_r[63], num: {sq_abs, 8'd0},
                        den: vd[DIV_D_W-1:0]};
          state_nxt = S_VAR_DIV;
        end else begin
          var_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_VAR_DIV: begin
        if (div_rsp.done) begin
          var_nxt   = sat64_sm(div_rsp.neg, div_rsp.quo);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          oc_nxt        = total_r;
          om_nxt        = mean_r;
          ov_nxt        = var_r;
          os_nxt        = ws_r;
          of_nxt        = fault_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (start_ws) begin
      vmt     = $signed({v_r[31], v_r});
      mul_req = '{start: 1'b1, neg: v_r[31], a: {24'd0, w_r}, b: abs33(vmt)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      mean_r      <= '0;
      sq_r        <= '0;
      ws_r        <= '0;
      mode_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      mean_r      <= mean_nxt;
      sq_r        <= sq_nxt;
      ws_r        <= ws_nxt;
      mode_r      <= mode_nxt;
    end
    op_r    <= op_nxt;
    w_r     <= w_nxt;
    v_r     <= v_nxt;
    fault_r <= fault_nxt;
    nm_r    <= nm_nxt;
    d_r     <= d_nxt;
    var_r   <= var_nxt;
    oc_r    <= oc_nxt;
    om_r    <= om_nxt;
    ov_r    <= ov_nxt;
    os_r    <= os_nxt;
    of_r    <= of_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_count        = oc_r;
  assign out_mean_out     = om_r;
  assign out_variance_out = ov_r;
  assign out_sum_out      = os_r;
  assign out_div_fault    = of_r;

  a_fault_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_fault) |-> (out_count == '0))
    else $error("fault reported with non-zero count");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_rsp.busy && div_rsp.busy))
    else $error("multiplier and divider busy together");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_valid) |=> (state_r == S_IDLE))
    else $error("left idle without a beat");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> out_valid_r)
    else $error("result not loaded");

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Running mean and variance testbench
// Drives weighted add, remove, clear and unused-op beats into the block.
// A scoreboard class predicts the count, mean, variance, sum and divide fault
// of each result and compares it against every beat taken from the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import rmv_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 900;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [TOT_W-1:0] count;
    logic [VAL_W-1:0] mean;
    logic [ACC_W-1:0] variance;
    logic [ACC_W-1:0] sum;
    logic             fault;
  } stats_t;

  class stats_scoreboard;
    logic [TOT_W-1:0]        total;
    logic signed [VAL_W-1:0] mean;
    logic signed [ACC_W-1:0] sq_dev;
    logic signed [ACC_W-1:0] wsum;
    logic                    mode;
    stats_t                  pending_q[$];
    int                      errors;
    int                      checked;
    int                      faults;
    int                      adds;
    int                      removes;

    function new();
      total = '0;
      mean = '0;
      sq_dev = '0;
      wsum = '0;
      mode = 1'b0;
      errors = 0;
      checked = 0;
      faults = 0;
      adds = 0;
      removes = 0;
    endfunction

    function logic signed [31:0] clip32(wide_t x);
      if (x > wide_t'(64'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (x < -wide_t'(64'sh8000_0000)) return 32'sh8000_0000;
      return x[31:0];
    endfunction

    function logic signed [63:0] clip64(wide_t x);
      wide_t hi, lo;
      hi = wide_t'(64'sh7FFF_FFFF_FFFF_FFFF);
      lo = -hi - 1;
      if (x > hi) return hi[63:0];
      if (x < lo) return lo[63:0];
      return x[63:0];
    endfunction

    function void note_beat(logic [1:0] op, logic [WGT_W-1:0] w, logic [VAL_W-1:0] v);
      wide_t wt, vl, mn, tt, d1, nm, dd, num, dv;
      stats_t e;
      wt = wide_t'({1'b0, w});
      vl = wide_t'($signed(v));
      mn = wide_t'(mean);
      tt = wide_t'({1'b0, total});
      e.fault = 1'b0;
      if (op == OP_ADD) begin
        adds++;
        tt = tt + wt;
        if (tt > wide_t'({1'b0, TOTAL_MAX})) tt = wide_t'({1'b0, TOTAL_MAX});
        total = tt[TOT_W-1:0];
        if (tt == 0) begin
          e.fault = 1'b1;
        end else begin
          d1 = vl - mn;
          nm = wide_t'(clip32(mn + (d1 <<< WEIGHT_FRAC_BITS) / tt));
          sq_dev = clip64(wide_t'(sq_dev) + d1 * (vl - nm));
          mean = nm[31:0];
        end
        wsum = clip64(wide_t'(wsum) + wt * vl);
      end else if (op == OP_REMOVE) begin
        removes++;
        if (total == ONE_W) begin
          total = '0;
          mean = '0;
          sq_dev = '0;
        end else begin
          dd = tt - wt;
          if (dd == 0) begin
            e.fault = 1'b1;
          end else begin
            num = tt * mn - (vl <<< WEIGHT_FRAC_BITS);
            nm = wide_t'(clip32(num / dd));
            sq_dev = clip64(wide_t'(sq_dev) - (vl - mn) * (vl - nm));
            mean = nm[31:0];
          end
          total = (dd > 0) ? dd[TOT_W-1:0] : '0;
        end
        wsum = clip64(wide_t'(wsum) - wt * vl);
      end else if (op == OP_CLEAR) begin
        total = '0;
        mean = '0;
        sq_dev = '0;
        wsum = '0;
      end
      if (e.fault) faults++;
      dv = wide_t'({1'b0, total}) - (mode ? wide_t'({1'b0, ONE_W}) : wide_t'(0));
      e.variance = '0;
      if (dv > wide_t'({1'b0, ONE_W}))
        e.variance = clip64((wide_t'(sq_dev) <<< WEIGHT_FRAC_BITS) / dv);
      e.count = total;
      e.mean = mean;
      e.sum = wsum;
      pending_q.push_back(e);
    endfunction

    function void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
    endfunction

    function void check_result(stats_t a);
      stats_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending", $time);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (a.count !== e.count) report("count", 64'(e.count), 64'(a.count));
      if (a.mean !== e.mean) report("mean", 64'(e.mean), 64'(a.mean));
      if (a.variance !== e.variance) report("variance", e.variance, a.variance);
      if (a.sum !== e.sum) report("sum", e.sum, a.sum);
      if (a.fault !== e.fault) report("div_fault", 64'(e.fault), 64'(a.fault));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = '0;
  logic [WGT_W-1:0] in_weight = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TOT_W-1:0] out_count;
  logic [VAL_W-1:0] out_mean_out;
  logic [ACC_W-1:0] out_variance_out;
  logic [ACC_W-1:0] out_sum_out;
  logic out_div_fault;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_sample_mode = 1'b0;

  stats_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  int cycles = 0;

  running_mean_variance_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_weight(in_weight), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_count(out_count), .out_mean_out(out_mean_out),
    .out_variance_out(out_variance_out), .out_sum_out(out_sum_out),
    .out_div_fault(out_div_fault),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_sample_mode(cfg_sample_mode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // collect results, then choose the next stall
  always @(posedge clk) begin
    stats_t a;
    if (rst_n && out_valid && !out_stall) begin
      a.count = out_count;
      a.mean = out_mean_out;
      a.variance = out_variance_out;
      a.sum = out_sum_out;
      a.fault = out_div_fault;
      sb.check_result(a);
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_beat(logic [1:0] op, logic [WGT_W-1:0] w, logic [VAL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_weight <= w;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_beat(op, w, v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_valid <= 1'b1;
    cfg_sample_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.mode = m;
  endtask

  task automatic random_beat();
    logic [1:0] op;
    logic [WGT_W-1:0] w;
    logic [VAL_W-1:0] v;
    int r;
    r = $urandom_range(99);
    op = (r < 55) ? OP_ADD : (r < 88) ? OP_REMOVE : (r < 93) ? OP_CLEAR : OP_UNUSED;
    r = $urandom_range(99);
    w = (r < 55) ? 16'd256 : (r < 80) ? WGT_W'($urandom_range(1, 1024)) :
        (r < 95) ? WGT_W'($urandom) : 16'd0;
    r = $urandom_range(99);
    v = (r < 60) ? VAL_W'($signed($urandom_range(0, 20 << 16)) - (10 << 16)) : $urandom;
    send_beat(op, w, v);
  endtask

  task automatic random_phase(int n, logic m, int s_pct, int r_pct, bit with_hold);
    drain();
    write_mode(m);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (with_hold) hold_req = 1'b1;
    repeat (n) random_beat();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(1'b0);
    send_beat(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    send_beat(OP_ADD, 16'd0, 32'h0001_0000);
    send_beat(OP_REMOVE, 16'd0, 32'h0000_0000);
    send_beat(OP_ADD, 16'd256, 32'h0001_0000);
    send_beat(OP_REMOVE, 16'd256, 32'h0001_0000);
    send_beat(OP_ADD, 16'd256, 32'h0003_0000);
    send_beat(OP_ADD, 16'd256, 32'hFFFD_0000);
    send_beat(OP_ADD, 16'd512, 32'h0010_0000);
    send_beat(OP_REMOVE, 16'd512, 32'h0010_0000);
    send_beat(OP_REMOVE, 16'hFFFF, 32'h7FFF_FFFF);
    send_beat(OP_UNUSED, 16'h1234, 32'h5678_9ABC);
    send_beat(OP_ADD, 16'hFFFF, 32'h7FFF_FFFF);
    send_beat(OP_ADD, 16'hFFFF, 32'h8000_0000);
    send_beat(OP_ADD, 16'h0001, 32'h7FFF_FFFF);
    send_beat(OP_REMOVE, 16'h0001, 32'h8000_0000);
    send_beat(OP_CLEAR, 16'd0, 32'd0);
    drain();
    write_mode(1'b1);
    send_beat(OP_ADD, 16'd256, 32'h0002_0000);
    send_beat(OP_ADD, 16'd256, 32'h0004_0000);
    send_beat(OP_ADD, 16'd256, 32'h0009_0000);
    send_beat(OP_REMOVE, 16'd256, 32'h0004_0000);
    send_beat(OP_UNUSED, 16'd0, 32'd0);
    random_phase(420, 1'b1, 32, 61, 1'b1);
    random_phase(420, 1'b0, 61, 32, 1'b0);
    random_phase(410, 1'b1, 0, 0, 1'b0);
    drain();
    $display("covered %0d results: %0d adds, %0d removes, %0d divide faults,",
             sb.checked, sb.adds, sb.removes, sb.faults);
    $display("both variance modes, idle and stall mixes and a long output hold-off");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/rmv_pkg.sv
rtl/rmv_mul.sv
rtl/rmv_div.sv
rtl/running_mean_variance_top.sv
dv/tb.sv
